/* rtl/sia_pkg.sv */
// Shared widths, constants and stencil addressing for the interface area density block.
package sia_pkg;

  localparam int SAMPLE_FRAC_BITS = 16;
  localparam int OUT_INT_BITS     = 24;
  localparam int SAMPLE_W         = SAMPLE_FRAC_BITS + 1;
  localparam int POS_W            = 5;
  localparam int STENCIL_N        = 27;
  localparam int CENTRE_POS       = 13;
  localparam int RECIP_W          = 32;
  localparam int DIFF_W           = SAMPLE_W + 4;
  localparam int ABS_W            = DIFF_W - 1;
  localparam int MUL_W            = 34;
  localparam int PROD_W           = 2 * MUL_W;
  localparam int SQ_W             = PROD_W + 2;
  localparam int ROOT_W           = SQ_W / 2 + 1;
  localparam int OUT_W            = OUT_INT_BITS + 16;
  localparam int ACC_W            = OUT_W + 4;
  localparam int COMP_SHIFT       = SAMPLE_FRAC_BITS + 2;

  localparam logic [OUT_W-1:0] MAG_MAX = '1;

  // Stencil position of corner k of the 2x2x2 sub-cube pointing into octant oct.
  // Bit a of k set means the point is offset along axis a towards the octant.
  function automatic logic [POS_W-1:0] point_pos(input logic [2:0] oct, input logic [2:0] k);
    logic [POS_W-1:0] ix;
    logic [POS_W-1:0] iy;
    logic [POS_W-1:0] iz;
    ix = k[0] ? (oct[0] ? POS_W'(2) : POS_W'(0)) : POS_W'(1);
    iy = k[1] ? (oct[1] ? POS_W'(2) : POS_W'(0)) : POS_W'(1);
    iz = k[2] ? (oct[2] ? POS_W'(2) : POS_W'(0)) : POS_W'(1);
    return POS_W'(9) * iz + POS_W'(3) * iy + ix;
  endfunction

endpackage

/* rtl/stencil_interface_area_density.sv */
// Top level: interface area density of one cell from a 3x3x3 marker stencil.
//
//  channel  direction  handshake               payload
//  in_      input      in_valid / in_ready      stencil_pos, sample_value, recip_half_d*,
//                                               last_sample
//  out_     output     out_valid / out_ready    area_density
//  cfg_     APB        psel, penable, pwrite    surface_level at byte address 0
//
// Each sample transfer is written straight into the stencil memory.
// A transfer flagged last_sample starts the cell computation: eight octants, each passing
// through memory reads, the shared multiplier and the bit-serial square root in turn.
// Reset is synchronous and active low; the sample memory itself is not cleared.
// A finished result waits in the output register while new samples keep loading.
module stencil_interface_area_density import sia_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [POS_W-1:0]     in_stencil_pos,
  input  logic [SAMPLE_W-1:0]  in_sample_value,
  input  logic [RECIP_W-1:0]   in_recip_half_dx,
  input  logic [RECIP_W-1:0]   in_recip_half_dy,
  input  logic [RECIP_W-1:0]   in_recip_half_dz,
  input  logic                 in_last_sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_W-1:0]     out_area_density,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_MUL, S_ROOT, S_HOLD} state_t;

  state_t               state_r;
  logic [SAMPLE_W-1:0]  level_r;
  logic [RECIP_W-1:0]   recip_r [3];
  logic [2:0]           oct_r;
  logic [3:0]           cnt_r;
  logic signed [DIFF_W-1:0] diff_r [3];
  logic [MUL_W-1:0]     comp_r [3];
  logic [PROD_W-1:0]    prod_r;
  logic [SQ_W-1:0]      sq_r;
  logic [ACC_W-1:0]     acc_r;
  logic                 out_valid_r;
  logic [OUT_W-1:0]     out_area_density_r;

  logic                 in_fire;
  logic                 cfg_write;
  logic                 rd_en;
  logic [POS_W-1:0]     rd_addr;
  logic [SAMPLE_W-1:0]  rd_data;
  logic [2:0]           k;
  logic [SAMPLE_W-1:0]  mark;
  logic [ABS_W-1:0]     diff_abs [3];
  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic [PROD_W-1:0]    mul_p;
  logic [MUL_W:0]       comp_rnd;
  logic                 root_start;
  logic                 root_done;
  logic [ROOT_W:0]      root;
  logic [ACC_W-1:0]     acc_sum;
  logic [ACC_W-1:0]     acc_fin;
  logic [ACC_W-1:0]     mean;
  logic [OUT_W-1:0]     mean_sat;
  logic                 out_load;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_write = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? 32'(level_r) : 32'd0;

  // Memory reads walk the eight corners of the sub-cube facing the current octant.
  assign rd_en   = (state_r == S_READ) && !cnt_r[3];
  assign rd_addr = point_pos(oct_r, cnt_r[2:0]);

  sia_store u_store (
    .clk     (clk),
    .wr_en   (in_fire && (in_stencil_pos < POS_W'(STENCIL_N))),
    .wr_addr (in_stencil_pos),
    .wr_data (in_sample_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The corner returned now is the one addressed in the previous cycle.
  // Corner zero is always the centre, which is thresholded against the level.
  assign k = cnt_r[2:0] - 3'd1;
  always_comb begin
    if (k != 3'd0) begin
      mark = rd_data;
    end else if (rd_data > level_r) begin
      mark = SAMPLE_W'(1) << SAMPLE_FRAC_BITS;
    end else if (rd_data < level_r) begin
      mark = '0;
    end else begin
      mark = SAMPLE_W'(1) << (SAMPLE_FRAC_BITS - 1);
    end
  end

  // The four one-sided differences along an axis sum to far corners minus near
  // corners; only the magnitude is used, so the octant sign drops out.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff_abs[a] = diff_r[a][DIFF_W-1] ? ABS_W'(-diff_r[a]) : ABS_W'(diff_r[a]);
    end
  end

  // One shared multiplier: three scalings by the reciprocals, then three squares.
  always_comb begin
    unique case (cnt_r)
      4'd0:    begin mul_a = MUL_W'(diff_abs[0]); mul_b = MUL_W'(recip_r[0]); end
      4'd1:    begin mul_a = MUL_W'(diff_abs[1]); mul_b = MUL_W'(recip_r[1]); end
      4'd2:    begin mul_a = MUL_W'(diff_abs[2]); mul_b = MUL_W'(recip_r[2]); end
      4'd3:    begin mul_a = comp_r[0];           mul_b = comp_r[0];           end
      4'd4:    begin mul_a = comp_r[1];           mul_b = comp_r[1];           end
      default: begin mul_a = comp_r[2];           mul_b = comp_r[2];           end
    endcase
  end
  assign mul_p    = mul_a * mul_b;
  assign comp_rnd = (MUL_W+1)'((prod_r + (PROD_W'(1) << (COMP_SHIFT - 1))) >> COMP_SHIFT);

  assign root_start = (state_r == S_MUL) && (cnt_r == 4'd6);

  sia_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (sq_r + SQ_W'(prod_r)),
    .done     (root_done),
    .root     (root)
  );

  // The mean comes from the running sum plus the last root, or from the stored
  // sum while a finished cell waits for the output register to free up.
  assign acc_sum  = acc_r + ACC_W'(root);
  assign acc_fin  = (state_r == S_HOLD) ? acc_r : acc_sum;
  assign mean     = (acc_fin + ACC_W'(4)) >> 3;
  assign mean_sat = (mean > ACC_W'(MAG_MAX)) ? MAG_MAX : OUT_W'(mean);

  assign out_load = (((state_r == S_ROOT) && root_done && (oct_r == 3'd7)) ||
                     (state_r == S_HOLD)) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= SAMPLE_W'(32768);
      oct_r       <= '0;
      cnt_r       <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write && (cfg_paddr[2] == 1'b0)) begin
        level_r <= cfg_pwdata[SAMPLE_W-1:0];
      end
      if (out_load) begin
        out_valid_r        <= 1'b1;
        out_area_density_r <= mean_sat;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire && in_last_sample) begin
            recip_r[0] <= in_recip_half_dx;
            recip_r[1] <= in_recip_half_dy;
            recip_r[2] <= in_recip_half_dz;
            oct_r      <= '0;
            cnt_r      <= '0;
            acc_r      <= '0;
            for (int a = 0; a < 3; a++) diff_r[a] <= '0;
            state_r    <= S_READ;
          end
        end
        S_READ: begin
          if (cnt_r != 4'd0) begin
            for (int a = 0; a < 3; a++) begin
              if (k[a]) diff_r[a] <= diff_r[a] + DIFF_W'(mark);
              else      diff_r[a] <= diff_r[a] - DIFF_W'(mark);
            end
          end
          if (cnt_r == 4'd8) begin
            cnt_r   <= '0;
            state_r <= S_MUL;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        S_MUL: begin
          prod_r <= mul_p;
          if (cnt_r >= 4'd1 && cnt_r <= 4'd3) begin
            comp_r[cnt_r[1:0] - 2'd1] <= MUL_W'(comp_rnd);
          end
          if (cnt_r == 4'd4) begin
            sq_r <= SQ_W'(prod_r);
          end else if (cnt_r == 4'd5) begin
            sq_r <= sq_r + SQ_W'(prod_r);
          end
          if (cnt_r == 4'd6) begin
            state_r <= S_ROOT;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        S_ROOT: begin
          if (root_done) begin
            acc_r <= acc_sum;
            cnt_r <= '0;
            for (int a = 0; a < 3; a++) diff_r[a] <= '0;
            if (oct_r != 3'd7) begin
              oct_r   <= oct_r + 3'd1;
              state_r <= S_READ;
            end else if (!out_valid_r || out_ready) begin
              state_r <= S_IDLE;
            end else begin
              state_r <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          if (!out_valid_r || out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_area_density = out_area_density_r;

endmodule

/* rtl/sia_store.sv */
// Stencil sample memory: one write port, one read port with registered data.
module sia_store import sia_pkg::*; (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [POS_W-1:0]    wr_addr,
  input  logic [SAMPLE_W-1:0] wr_data,
  input  logic                rd_en,
  input  logic [POS_W-1:0]    rd_addr,
  output logic [SAMPLE_W-1:0] rd_data
);

  logic [SAMPLE_W-1:0] mem [STENCIL_N];
  logic [SAMPLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/sia_sqrt.sv */
// Bit-serial integer square root, rounded to nearest, two radicand bits per cycle.
module sia_sqrt import sia_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output logic              done,
  output logic [ROOT_W:0]   root
);

  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SQ_W-1:0]   src_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [ROOT_W:0]   res_r;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              take;

  assign rem_sh = {rem_r[REM_W-3:0], src_r[SQ_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(SQ_W / 2);
        src_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          src_r  <= {src_r[SQ_W-3:0], 2'b00};
          rem_r  <= take ? rem_sh - trial : rem_sh;
          root_r <= {root_r[ROOT_W-2:0], take};
          cnt_r  <= cnt_r - CNT_W'(1);
        end else begin
          // The remainder is radicand minus root squared; round up above root.
          res_r  <= (rem_r > REM_W'(root_r)) ? {1'b0, root_r} + (ROOT_W+1)'(1)
                                             : {1'b0, root_r};
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r;

endmodule
